// ----- hdl/breath_cycle_sequencer_macros.svh -----
// Assertion helpers for the sequencer core (bcs_core includes them).
// They expect signals named clk and rst_n in the using module.
`ifndef BREATH_CYCLE_SEQUENCER_MACROS_SVH
`define BREATH_CYCLE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define BCS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// next-cycle implication
`define BCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// ----- hdl/bcs_pkg.sv -----
package bcs_pkg;

    localparam int TIME_W   = 15;
    localparam int TICK_W   = 10;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [TIME_W-1:0] ELAPSED_MAX   = 15'd32767;
    localparam logic [TICK_W-1:0] TICK_MS_RESET = 10'd10;
    localparam logic [TIME_W-1:0] MAX_POS_RESET = 15'd32767;

    // phase codes
    localparam logic [STATUS_W-1:0] PH_FIRST_RUN  = 3'd0;
    localparam logic [STATUS_W-1:0] PH_EXP_START  = 3'd1;
    localparam logic [STATUS_W-1:0] PH_WAIT_ZERO  = 3'd2;
    localparam logic [STATUS_W-1:0] PH_EXP_WAIT   = 3'd3;
    localparam logic [STATUS_W-1:0] PH_INSP_INIT  = 3'd4;
    localparam logic [STATUS_W-1:0] PH_INSP       = 3'd5;
    localparam logic [STATUS_W-1:0] PH_MAX_POS    = 3'd6;

    // motor commands
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ZERO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPEED = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_TICK_MS = 1'b0;
    localparam logic REG_MAX_POS = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [TIME_W-1:0] max_position;
    } cfg_t;

endpackage

// ----- hdl/bcs_regs.sv -----
module bcs_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [bcs_pkg::ADDR_W-1:0] paddr,
    input  logic [bcs_pkg::DATA_W-1:0] pwdata,
    output logic [bcs_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    output bcs_pkg::cfg_t         cfg
);
    import bcs_pkg::*;

    logic [TICK_W-1:0] tick_ms_reg;
    logic [TIME_W-1:0] max_pos_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg <= TICK_MS_RESET;
            max_pos_reg <= MAX_POS_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_TICK_MS)
                tick_ms_reg <= pwdata[TICK_W-1:0];
            else
                max_pos_reg <= pwdata[TIME_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_POS)
            prdata = {{(DATA_W-TIME_W){1'b0}}, max_pos_reg};
        else
            prdata = {{(DATA_W-TICK_W){1'b0}}, tick_ms_reg};
    end

    assign cfg.tick_ms      = tick_ms_reg;
    assign cfg.max_position = max_pos_reg;

endmodule

// ----- hdl/bcs_core.sv -----
module bcs_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcs_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bcs_pkg::TIME_W-1:0]    insp_time,
    input  logic [bcs_pkg::TIME_W-1:0]    exp_time,
    input  logic [bcs_pkg::TIME_W-1:0]    motor_position,
    input  logic                          ctrl_stopped,
    input  logic                          mode_change,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bcs_pkg::STATUS_W-1:0]  status,
    output logic                          cmd_valid,
    output logic [bcs_pkg::CMD_W-1:0]     cmd_mode,
    output logic [bcs_pkg::COUNT_W-1:0]   breath_count,
    output logic                          volume_restart,
    output logic                          leave_mode,
    output logic                          led_on
);
    import bcs_pkg::*;
`include "breath_cycle_sequencer_macros.svh"

    // input stage
    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_insp_reg;
    logic [TIME_W-1:0] s1_exp_reg;
    logic [TIME_W-1:0] s1_pos_reg;
    logic              s1_stopped_reg;
    logic              s1_change_reg;

    // sequencer state
    logic [STATUS_W-1:0] phase_reg,   phase_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   insp_reg,    insp_next;
    logic [TIME_W-1:0]   exp_reg,     exp_next;
    logic [COUNT_W-1:0]  breaths_reg, breaths_next;
    logic                lamp_reg,    lamp_next;

    // result stage
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                cmd_valid_reg, cmd_valid_next;
    logic [CMD_W-1:0]    cmd_mode_reg,  cmd_mode_next;
    logic                vol_reset_reg, vol_reset_next;
    logic                leave_reg,     leave_next;

    logic              step;
    logic              s1_free;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_adv;

    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free  = !s1_valid_reg || step;
    assign in_ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            s1_insp_reg    <= insp_time;
            s1_exp_reg     <= exp_time;
            s1_pos_reg     <= motor_position;
            s1_stopped_reg <= ctrl_stopped;
            s1_change_reg  <= mode_change;
        end
    end

    // saturating elapsed-time advance
    assign time_sum = {1'b0, elapsed_reg} + {{(TIME_W+1-TICK_W){1'b0}}, cfg.tick_ms};
    assign time_adv = time_sum[TIME_W] ? ELAPSED_MAX : time_sum[TIME_W-1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        insp_next      = insp_reg;
        exp_next       = exp_reg;
        breaths_next   = breaths_reg;
        lamp_next      = lamp_reg;
        cmd_valid_next = 1'b0;
        cmd_mode_next  = CMD_STOP;
        vol_reset_next = 1'b0;
        leave_next     = 1'b0;
        case (phase_reg)
            PH_FIRST_RUN:
            begin
                insp_next  = s1_insp_reg;
                exp_next   = s1_exp_reg;
                phase_next = PH_EXP_START;
            end
            PH_EXP_START:
            begin
                cmd_valid_next = 1'b1;
                cmd_mode_next  = CMD_ZERO;
                lamp_next      = 1'b1;
                elapsed_next   = '0;
                phase_next     = PH_WAIT_ZERO;
            end
            PH_WAIT_ZERO:
            begin
                elapsed_next = time_adv;
                if (s1_stopped_reg)
                    phase_next = PH_EXP_WAIT;
            end
            PH_EXP_WAIT:
            begin
                elapsed_next = time_adv;
                if (time_adv > exp_reg)
                    phase_next = PH_INSP_INIT;
            end
            PH_INSP_INIT:
            begin
                if (s1_change_reg)
                begin
                    leave_next = 1'b1;
                    phase_next = PH_FIRST_RUN;
                end
                else
                begin
                    insp_next      = s1_insp_reg;
                    exp_next       = s1_exp_reg;
                    vol_reset_next = 1'b1;
                    breaths_next   = breaths_reg + COUNT_W'(1);
                    cmd_valid_next = 1'b1;
                    cmd_mode_next  = CMD_SPEED;
                    elapsed_next   = '0;
                    phase_next     = PH_INSP;
                end
            end
            PH_INSP:
            begin
                elapsed_next = time_adv;
                lamp_next    = 1'b0;
                if (time_adv > insp_reg)
                begin
                    cmd_valid_next = 1'b1;
                    phase_next     = PH_EXP_START;
                end
                // reaching the end stop wins over time-out
                if (s1_pos_reg >= cfg.max_position)
                begin
                    cmd_valid_next = 1'b1;
                    phase_next     = PH_MAX_POS;
                end
            end
            PH_MAX_POS:
            begin
                elapsed_next = time_adv;
                if (time_adv > insp_reg)
                begin
                    cmd_valid_next = 1'b1;
                    phase_next     = PH_EXP_START;
                end
            end
            default:
            begin
                cmd_valid_next = 1'b1;
                phase_next     = PH_FIRST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST_RUN;
            elapsed_reg   <= '0;
            insp_reg      <= '0;
            exp_reg       <= '0;
            breaths_reg   <= '0;
            lamp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                insp_reg    <= insp_next;
                exp_reg     <= exp_next;
                breaths_reg <= breaths_next;
                lamp_reg    <= lamp_next;
            end
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg    <= phase_reg;
            cmd_valid_reg <= cmd_valid_next;
            cmd_mode_reg  <= cmd_mode_next;
            vol_reset_reg <= vol_reset_next;
            leave_reg     <= leave_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign cmd_valid      = cmd_valid_reg;
    assign cmd_mode       = cmd_mode_reg;
    assign breath_count   = breaths_reg;
    assign volume_restart = vol_reset_reg;
    assign leave_mode     = leave_reg;
    assign led_on         = lamp_reg;

    `BCS_ASSERT_NEXT(a_step_gives_result, step, out_valid_reg)
    `BCS_ASSERT_NOW(a_speed_with_vol_reset,
        out_valid_reg && cmd_valid_reg && (cmd_mode_reg == CMD_SPEED), vol_reset_reg)
    `BCS_ASSERT_NOW(a_leave_only_at_init,
        out_valid_reg && leave_reg, (status_reg == PH_INSP_INIT) && !cmd_valid_reg)
    `BCS_ASSERT_NOW(a_idle_cmd_is_stop,
        out_valid_reg && !cmd_valid_reg, cmd_mode_reg == CMD_STOP)
    `BCS_ASSERT_NEXT(a_count_moves_on_init,
        step && !(phase_reg == PH_INSP_INIT && !s1_change_reg), $stable(breaths_reg))

endmodule

// ----- hdl/breath_cycle_sequencer.sv -----
// Breath cycle sequencer.
// Input channel (in_valid/in_ready): one item per time-slice tick carrying
// insp_time, exp_time, motor_position, ctrl_stopped and mode_change.
// Output channel (out_valid/out_ready): one result item per tick with the
// phase before the step, the motor command, breath count, volume restart and
// leave-mode pulses and the expiration lamp.
// An item passes an input register, the next-state logic and a result
// register; out_valid rises once the result register is loaded, and one item
// can be accepted every cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; after that in_ready drops until the
// result is taken.
// Registers over the APB port: tick_ms at 0x0, max_position at 0x4; write
// them only while no item is in flight. pready is tied high.
// Reset puts the sequencer in first run with cleared times, count and lamp,
// tick_ms at 10 and max_position at 32767.
module breath_cycle_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcs_pkg::ADDR_W-1:0]    paddr,
    input  logic [bcs_pkg::DATA_W-1:0]    pwdata,
    output logic [bcs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bcs_pkg::TIME_W-1:0]    insp_time,
    input  logic [bcs_pkg::TIME_W-1:0]    exp_time,
    input  logic [bcs_pkg::TIME_W-1:0]    motor_position,
    input  logic                          ctrl_stopped,
    input  logic                          mode_change,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bcs_pkg::STATUS_W-1:0]  status,
    output logic                          cmd_valid,
    output logic [bcs_pkg::CMD_W-1:0]     cmd_mode,
    output logic [bcs_pkg::COUNT_W-1:0]   breath_count,
    output logic                          volume_restart,
    output logic                          leave_mode,
    output logic                          led_on
);
    import bcs_pkg::*;

    cfg_t cfg;

    bcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcs_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .insp_time      (insp_time),
        .exp_time       (exp_time),
        .motor_position (motor_position),
        .ctrl_stopped   (ctrl_stopped),
        .mode_change    (mode_change),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .cmd_valid      (cmd_valid),
        .cmd_mode       (cmd_mode),
        .breath_count   (breath_count),
        .volume_restart (volume_restart),
        .leave_mode     (leave_mode),
        .led_on         (led_on)
    );

endmodule
